[rtl/core/rnrh_pkg.sv]
// shared types and constants of the radio node registration handler
package rnrh_pkg;

  localparam int SlotCount = 5;
  localparam int SlotIdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int PipeW     = 3;
  localparam int ByteW     = 8;
  localparam int CfgIdxW   = 3;
  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);
  localparam int DevCntW   = 3;

  localparam logic [CfgIdxW-1:0] CFG_OWN_ID      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEND_REQ    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEND_PERMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_NOT_REG     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NO_PIPE     = 3'd4;

  localparam logic [ByteW-1:0] RST_OWN_ID      = 8'd0;
  localparam logic [ByteW-1:0] RST_SEND_REQ    = 8'd4;
  localparam logic [ByteW-1:0] RST_SEND_PERMIT = 8'd5;
  localparam logic [ByteW-1:0] RST_NOT_REG     = 8'd12;
  localparam logic [ByteW-1:0] RST_NO_PIPE     = 8'd11;

  localparam logic [ByteW-1:0] GRANT_KIND     = 8'd1;
  localparam logic [ByteW-1:0] ERR_KIND       = 8'd3;
  localparam logic [ByteW-1:0] PIPE_REQ_BYTE  = 8'd1;
  localparam logic [ByteW-1:0] RST_LAST_BYTE2 = 8'd2;
  localparam logic [ByteW-1:0] RST_LAST_BYTE3 = 8'd3;
  localparam logic [PipeW-1:0] SERVICE_PIPE   = 3'd0;
  localparam logic [DevCntW-1:0] DEV_CNT_MAX  = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0] own_node_id;
    logic [ByteW-1:0] send_request_code;
    logic [ByteW-1:0] send_permit_code;
    logic [ByteW-1:0] not_registered_code;
    logic [ByteW-1:0] no_pipe_code;
  } cfg_t;

  typedef struct packed {
    logic             is_req;
    logic [ByteW-1:0] source_id;
    logic [ByteW-1:0] kind_byte;
  } item_t;

endpackage

[rtl/core/radio_node_registration_handler.sv]
// top level of the radio node registration handler
// an answer strobes on out_valid after the queue entry and the output register
// throughput: one packet per cycle while the two-entry queue has room;
// busy is high while the queue is full
// reset: synchronous active-low rst_n frees all slots and loads register defaults
// the receiver cannot stall: each answer is shown for exactly one cycle
module radio_node_registration_handler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rnrh_pkg::PipeW-1:0]    in_rx_pipe,
  input  logic [rnrh_pkg::ByteW-1:0]    in_source_id,
  input  logic [rnrh_pkg::ByteW-1:0]    in_kind_byte,
  input  logic [rnrh_pkg::ByteW-1:0]    in_request_byte,
  input  logic [rnrh_pkg::ByteW-1:0]    in_target_id,
  output logic                          out_valid,
  output logic [rnrh_pkg::PipeW-1:0]    out_tx_pipe,
  output logic [rnrh_pkg::ByteW-1:0]    out_tx_addr_first,
  output logic [rnrh_pkg::ByteW-1:0]    out_byte0,
  output logic [rnrh_pkg::ByteW-1:0]    out_byte1,
  output logic [rnrh_pkg::ByteW-1:0]    out_byte2,
  output logic [rnrh_pkg::ByteW-1:0]    out_byte3,
  output logic [rnrh_pkg::ByteW-1:0]    out_byte4,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rnrh_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rnrh_pkg::ByteW-1:0]    cfg_data
);

  rnrh_pkg::cfg_t  cfg_r, cfg_nxt;
  rnrh_pkg::item_t q_in, q_out;
  logic            q_push, q_pop, q_not_empty, q_full;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rnrh_pkg::CFG_OWN_ID:      cfg_nxt.own_node_id         = cfg_data;
        rnrh_pkg::CFG_SEND_REQ:    cfg_nxt.send_request_code   = cfg_data;
        rnrh_pkg::CFG_SEND_PERMIT: cfg_nxt.send_permit_code    = cfg_data;
        rnrh_pkg::CFG_NOT_REG:     cfg_nxt.not_registered_code = cfg_data;
        rnrh_pkg::CFG_NO_PIPE:     cfg_nxt.no_pipe_code        = cfg_data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node_id         <= rnrh_pkg::RST_OWN_ID;
      cfg_r.send_request_code   <= rnrh_pkg::RST_SEND_REQ;
      cfg_r.send_permit_code    <= rnrh_pkg::RST_SEND_PERMIT;
      cfg_r.not_registered_code <= rnrh_pkg::RST_NOT_REG;
      cfg_r.no_pipe_code        <= rnrh_pkg::RST_NO_PIPE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rnrh_front u_front (
    .start           (start),
    .busy            (busy),
    .in_rx_pipe      (in_rx_pipe),
    .in_source_id    (in_source_id),
    .in_kind_byte    (in_kind_byte),
    .in_request_byte (in_request_byte),
    .in_target_id    (in_target_id),
    .cfg             (cfg_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  rnrh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  rnrh_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_not_empty),
    .q_data            (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_tx_pipe       (out_tx_pipe),
    .out_tx_addr_first (out_tx_addr_first),
    .out_byte0         (out_byte0),
    .out_byte1         (out_byte1),
    .out_byte2         (out_byte2),
    .out_byte3         (out_byte3),
    .out_byte4         (out_byte4)
  );

  a_out_from_queue : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q_not_empty))
    else $error("answer without a queued packet");

  a_service_addr : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_pipe == rnrh_pkg::SERVICE_PIPE) |-> out_tx_addr_first == out_byte4)
    else $error("service answer address differs from destination");

  a_data_addr : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_pipe != rnrh_pkg::SERVICE_PIPE) |->
      (out_tx_addr_first == 8'(out_tx_pipe) && out_byte1 == cfg_r.send_permit_code))
    else $error("permission answer fields inconsistent");

  a_full_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !q_pop) |=> q_full)
    else $error("queue drained without a pop");

endmodule

[rtl/core/rnrh_queue.sv]
// two-entry queue between the classifier and the slot engine
module rnrh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rnrh_pkg::item_t push_data,
  input  logic            pop,
  output rnrh_pkg::item_t pop_data,
  output logic            not_empty,
  output logic            full
);

  rnrh_pkg::item_t                  mem [rnrh_pkg::QDepth];
  logic [rnrh_pkg::QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [rnrh_pkg::QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [rnrh_pkg::QCntW-1:0]       count_r, count_nxt;
  logic                             do_push, do_pop;

  assign full      = (count_r == rnrh_pkg::QCntW'(rnrh_pkg::QDepth));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == rnrh_pkg::QPtrW'(rnrh_pkg::QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == rnrh_pkg::QPtrW'(rnrh_pkg::QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/rnrh_front.sv]
// packet intake: accepts headers and drops service packets not meant for this hub
module rnrh_front (
  input  logic                        start,
  output logic                        busy,
  input  logic [rnrh_pkg::PipeW-1:0]  in_rx_pipe,
  input  logic [rnrh_pkg::ByteW-1:0]  in_source_id,
  input  logic [rnrh_pkg::ByteW-1:0]  in_kind_byte,
  input  logic [rnrh_pkg::ByteW-1:0]  in_request_byte,
  input  logic [rnrh_pkg::ByteW-1:0]  in_target_id,
  input  rnrh_pkg::cfg_t              cfg,
  input  logic                        q_full,
  output logic                        q_push,
  output rnrh_pkg::item_t             q_data
);

  logic accept;
  logic is_service;
  logic for_us;

  assign busy       = q_full;
  assign accept     = start && !q_full;
  assign is_service = (in_rx_pipe == rnrh_pkg::SERVICE_PIPE);
  assign for_us     = (in_target_id == cfg.own_node_id) &&
                      (in_request_byte == rnrh_pkg::PIPE_REQ_BYTE);

  assign q_push           = accept && (!is_service || for_us);
  assign q_data.is_req    = is_service;
  assign q_data.source_id = in_source_id;
  assign q_data.kind_byte = in_kind_byte;

endmodule

[rtl/core/rnrh_back.sv]
// slot engine: registration table lookup, slot grant and answer build
module rnrh_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rnrh_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  rnrh_pkg::item_t             q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [rnrh_pkg::PipeW-1:0]  out_tx_pipe,
  output logic [rnrh_pkg::ByteW-1:0]  out_tx_addr_first,
  output logic [rnrh_pkg::ByteW-1:0]  out_byte0,
  output logic [rnrh_pkg::ByteW-1:0]  out_byte1,
  output logic [rnrh_pkg::ByteW-1:0]  out_byte2,
  output logic [rnrh_pkg::ByteW-1:0]  out_byte3,
  output logic [rnrh_pkg::ByteW-1:0]  out_byte4
);

  localparam int N  = rnrh_pkg::SlotCount;
  localparam int IW = rnrh_pkg::SlotIdxW;
  localparam int BW = rnrh_pkg::ByteW;
  localparam int PW = rnrh_pkg::PipeW;

  logic [N-1:0]                    slot_used_r, slot_used_nxt;
  logic [BW-1:0]                   slot_node_id_r   [N];
  logic [BW-1:0]                   slot_node_type_r [N];
  logic [rnrh_pkg::DevCntW-1:0]    device_count_r, device_count_nxt;
  logic [BW-1:0]                   last_byte2_r, last_byte2_nxt;
  logic [BW-1:0]                   last_byte3_r, last_byte3_nxt;

  logic [N-1:0]  match;
  logic          hit, has_free;
  logic [IW-1:0] hit_idx, free_idx;
  logic          wr_slot;

  logic          res_valid;
  logic [PW-1:0] res_pipe;
  logic [BW-1:0] res_addr, res_b0, res_b1, res_b2, res_b3, res_b4;

  logic          out_valid_r;
  logic [PW-1:0] out_tx_pipe_r;
  logic [BW-1:0] out_addr_r, out_b0_r, out_b1_r, out_b2_r, out_b3_r, out_b4_r;

  assign q_pop = q_valid;

  always_comb begin
    hit      = 1'b0;
    has_free = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      match[i] = slot_used_r[i] && (slot_node_id_r[i] == q_data.source_id);
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!slot_used_r[i]) begin
        has_free = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    res_valid        = 1'b0;
    res_pipe         = rnrh_pkg::SERVICE_PIPE;
    res_addr         = q_data.source_id;
    res_b0           = cfg.own_node_id;
    res_b1           = '0;
    res_b2           = rnrh_pkg::ERR_KIND;
    res_b3           = cfg.no_pipe_code;
    res_b4           = q_data.source_id;
    wr_slot          = 1'b0;
    slot_used_nxt    = slot_used_r;
    device_count_nxt = device_count_r;
    last_byte2_nxt   = last_byte2_r;
    last_byte3_nxt   = last_byte3_r;
    if (q_valid) begin
      if (q_data.is_req) begin
        res_valid = 1'b1;
        if (hit) begin
          res_b2 = rnrh_pkg::GRANT_KIND;
          res_b3 = BW'(hit_idx) + 1'b1;
        end else if (has_free) begin
          res_b2                  = rnrh_pkg::GRANT_KIND;
          res_b3                  = BW'(free_idx) + 1'b1;
          wr_slot                 = 1'b1;
          slot_used_nxt[free_idx] = 1'b1;
          if (device_count_r < rnrh_pkg::DEV_CNT_MAX) begin
            device_count_nxt = device_count_r + 1'b1;
          end
        end
        last_byte2_nxt = res_b2;
        last_byte3_nxt = res_b3;
      end else if (!hit) begin
        res_valid      = 1'b1;
        res_b3         = cfg.not_registered_code;
        last_byte2_nxt = res_b2;
        last_byte3_nxt = res_b3;
      end else if (q_data.kind_byte == cfg.send_request_code) begin
        res_valid = 1'b1;
        res_pipe  = PW'(hit_idx) + 1'b1;
        res_addr  = BW'(hit_idx) + 1'b1;
        res_b1    = cfg.send_permit_code;
        res_b2    = last_byte2_r;
        res_b3    = last_byte3_r;
        res_b4    = slot_node_id_r[hit_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r    <= '0;
      device_count_r <= '0;
      last_byte2_r   <= rnrh_pkg::RST_LAST_BYTE2;
      last_byte3_r   <= rnrh_pkg::RST_LAST_BYTE3;
      out_valid_r    <= 1'b0;
    end else begin
      slot_used_r    <= slot_used_nxt;
      device_count_r <= device_count_nxt;
      last_byte2_r   <= last_byte2_nxt;
      last_byte3_r   <= last_byte3_nxt;
      out_valid_r    <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_slot) begin
      slot_node_id_r[free_idx]   <= q_data.source_id;
      slot_node_type_r[free_idx] <= q_data.kind_byte;
    end
    out_tx_pipe_r <= res_pipe;
    out_addr_r    <= res_addr;
    out_b0_r      <= res_b0;
    out_b1_r      <= res_b1;
    out_b2_r      <= res_b2;
    out_b3_r      <= res_b3;
    out_b4_r      <= res_b4;
  end

  assign out_valid         = out_valid_r;
  assign out_tx_pipe       = out_tx_pipe_r;
  assign out_tx_addr_first = out_addr_r;
  assign out_byte0         = out_b0_r;
  assign out_byte1         = out_b1_r;
  assign out_byte2         = out_b2_r;
  assign out_byte3         = out_b3_r;
  assign out_byte4         = out_b4_r;

endmodule

[bench/tb_radio_node_registration_handler.sv]
// testbench for the radio node registration handler: directed and random packets against a predictor
`timescale 1ns / 100ps

module tb_radio_node_registration_handler;
  import rnrh_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [PipeW-1:0] tx_pipe;
    logic [ByteW-1:0] tx_addr_first;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
    logic [ByteW-1:0] byte2;
    logic [ByteW-1:0] byte3;
    logic [ByteW-1:0] byte4;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PipeW-1:0] in_rx_pipe = '0;
  logic [ByteW-1:0] in_source_id = '0;
  logic [ByteW-1:0] in_kind_byte = '0;
  logic [ByteW-1:0] in_request_byte = '0;
  logic [ByteW-1:0] in_target_id = '0;
  logic out_valid;
  logic [PipeW-1:0] out_tx_pipe;
  logic [ByteW-1:0] out_tx_addr_first;
  logic [ByteW-1:0] out_byte0;
  logic [ByteW-1:0] out_byte1;
  logic [ByteW-1:0] out_byte2;
  logic [ByteW-1:0] out_byte3;
  logic [ByteW-1:0] out_byte4;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0] cfg_data = '0;

  // predictor state
  cfg_t hub_cfg;
  logic slot_taken [SlotCount];
  logic [ByteW-1:0] slot_owner [SlotCount];
  logic [ByteW-1:0] last_kind_sent;
  logic [ByteW-1:0] last_code_sent;
  answer_t answers_due [$];

  answer_t seen_answer;
  answer_t due_answer;
  bit answer_made;
  int mismatch_count = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  radio_node_registration_handler u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_rx_pipe        (in_rx_pipe),
    .in_source_id      (in_source_id),
    .in_kind_byte      (in_kind_byte),
    .in_request_byte   (in_request_byte),
    .in_target_id      (in_target_id),
    .out_valid         (out_valid),
    .out_tx_pipe       (out_tx_pipe),
    .out_tx_addr_first (out_tx_addr_first),
    .out_byte0         (out_byte0),
    .out_byte1         (out_byte1),
    .out_byte2         (out_byte2),
    .out_byte3         (out_byte3),
    .out_byte4         (out_byte4),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic answer_t service_answer(input logic [ByteW-1:0] kind,
                                             input logic [ByteW-1:0] code,
                                             input logic [ByteW-1:0] dest);
    answer_t a;
    a.tx_pipe       = SERVICE_PIPE;
    a.tx_addr_first = dest;
    a.byte0         = hub_cfg.own_node_id;
    a.byte1         = '0;
    a.byte2         = kind;
    a.byte3         = code;
    a.byte4         = dest;
    last_kind_sent  = kind;
    last_code_sent  = code;
    return a;
  endfunction

  function automatic bit predict_answer(input logic [PipeW-1:0] pipe,
                                        input logic [ByteW-1:0] src,
                                        input logic [ByteW-1:0] kind,
                                        input logic [ByteW-1:0] req,
                                        input logic [ByteW-1:0] tgt,
                                        output answer_t ans);
    int hit;
    int free_slot;
    int i;
    hit = -1;
    free_slot = -1;
    ans = '0;
    // scan downward so the lowest matching and lowest free slot win
    for (i = SlotCount - 1; i >= 0; i--) begin
      if (slot_taken[i] && slot_owner[i] == src) hit = i;
      if (!slot_taken[i]) free_slot = i;
    end
    if (pipe == SERVICE_PIPE) begin
      if (tgt != hub_cfg.own_node_id || req != PIPE_REQ_BYTE) return 1'b0;
      if (hit >= 0) begin
        ans = service_answer(GRANT_KIND, ByteW'(hit + 1), src);
      end else if (free_slot >= 0) begin
        slot_taken[free_slot] = 1'b1;
        slot_owner[free_slot] = src;
        ans = service_answer(GRANT_KIND, ByteW'(free_slot + 1), src);
      end else begin
        ans = service_answer(ERR_KIND, hub_cfg.no_pipe_code, src);
      end
      return 1'b1;
    end
    if (hit < 0) begin
      ans = service_answer(ERR_KIND, hub_cfg.not_registered_code, src);
      return 1'b1;
    end
    if (kind != hub_cfg.send_request_code) return 1'b0;
    ans.tx_pipe       = PipeW'(hit + 1);
    ans.tx_addr_first = ByteW'(hit + 1);
    ans.byte0         = hub_cfg.own_node_id;
    ans.byte1         = hub_cfg.send_permit_code;
    ans.byte2         = last_kind_sent;
    ans.byte3         = last_code_sent;
    ans.byte4         = slot_owner[hit];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input answer_t want, input answer_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected pipe %0d addr %h bytes %h %h %h %h %h",
               $realtime, what, want.tx_pipe, want.tx_addr_first, want.byte0, want.byte1,
               want.byte2, want.byte3, want.byte4);
      $display("%0t %s: actual   pipe %0d addr %h bytes %h %h %h %h %h",
               $realtime, what, got.tx_pipe, got.tx_addr_first, got.byte0, got.byte1,
               got.byte2, got.byte3, got.byte4);
    end
  endtask

  // result checker, config tracker and input predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      hub_cfg.own_node_id         = RST_OWN_ID;
      hub_cfg.send_request_code   = RST_SEND_REQ;
      hub_cfg.send_permit_code    = RST_SEND_PERMIT;
      hub_cfg.not_registered_code = RST_NOT_REG;
      hub_cfg.no_pipe_code        = RST_NO_PIPE;
      for (int i = 0; i < SlotCount; i++) begin
        slot_taken[i] = 1'b0;
        slot_owner[i] = '0;
      end
      last_kind_sent = RST_LAST_BYTE2;
      last_code_sent = RST_LAST_BYTE3;
    end else begin
      if (out_valid) begin
        seen_answer = '{out_tx_pipe, out_tx_addr_first, out_byte0, out_byte1,
                        out_byte2, out_byte3, out_byte4};
        if (answers_due.size() == 0) begin
          report_mismatch("unexpected answer", '0, seen_answer);
        end else begin
          due_answer = answers_due.pop_front();
          if (seen_answer !== due_answer) report_mismatch("answer", due_answer, seen_answer);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_ID:      hub_cfg.own_node_id         = cfg_data;
          CFG_SEND_REQ:    hub_cfg.send_request_code   = cfg_data;
          CFG_SEND_PERMIT: hub_cfg.send_permit_code    = cfg_data;
          CFG_NOT_REG:     hub_cfg.not_registered_code = cfg_data;
          CFG_NO_PIPE:     hub_cfg.no_pipe_code        = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        answer_made = predict_answer(in_rx_pipe, in_source_id, in_kind_byte,
                                     in_request_byte, in_target_id, due_answer);
        if (answer_made) answers_due.push_back(due_answer);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("radio_node_registration_handler: mismatch");
      $finish;
    end
  end

  task automatic send_packet(input logic [PipeW-1:0] pipe, input logic [ByteW-1:0] src,
                             input logic [ByteW-1:0] kind, input logic [ByteW-1:0] req,
                             input logic [ByteW-1:0] tgt);
    while (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      in_source_id <= ByteW'($urandom);
      in_request_byte <= ByteW'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    in_rx_pipe <= pipe;
    in_source_id <= src;
    in_kind_byte <= kind;
    in_request_byte <= req;
    in_target_id <= tgt;
    do @(posedge clk); while (busy);
  endtask

  // sender pause until every answer is back and in-flight silent packets are done
  task automatic drain_answers();
    start <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input cfg_t values);
    logic [CfgIdxW-1:0] order [5];
    logic [ByteW-1:0] data [5];
    drain_answers();
    order = '{CFG_OWN_ID, CFG_SEND_REQ, CFG_SEND_PERMIT, CFG_NOT_REG, CFG_NO_PIPE};
    data = '{values.own_node_id, values.send_request_code, values.send_permit_code,
             values.not_registered_code, values.no_pipe_code};
    cfg_valid <= 1'b1;
    // an out-of-range index must be ignored
    cfg_index <= CfgIdxW'($urandom_range(CFG_NO_PIPE + 1, (1 << CfgIdxW) - 1));
    cfg_data <= ByteW'($urandom);
    do @(posedge clk); while (!cfg_ready);
    for (int k = 0; k < 5; k++) begin
      cfg_index <= order[k];
      cfg_data <= data[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ByteW-1:0] pick_node_id();
    int s;
    s = $urandom_range(SlotCount - 1);
    if (slot_taken[s]) return slot_owner[s];
    return ByteW'($urandom);
  endfunction

  task automatic test_service_filter();
    send_packet(SERVICE_PIPE, 8'h10, 8'h00, PIPE_REQ_BYTE, hub_cfg.own_node_id + 8'd1);
    send_packet(SERVICE_PIPE, 8'h10, 8'h00, 8'h00, hub_cfg.own_node_id);
    send_packet(SERVICE_PIPE, 8'h10, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_registration();
    send_packet(3'd3, 8'h55, hub_cfg.send_request_code, 8'h00, 8'h00);
    send_packet(SERVICE_PIPE, 8'h00, 8'hC1, PIPE_REQ_BYTE, hub_cfg.own_node_id);
    send_packet(SERVICE_PIPE, 8'h00, 8'hC1, PIPE_REQ_BYTE, hub_cfg.own_node_id);
    send_packet(SERVICE_PIPE, 8'hFF, 8'hC2, PIPE_REQ_BYTE, hub_cfg.own_node_id);
  endtask

  task automatic test_data_pipe();
    send_packet(3'd1, 8'h00, hub_cfg.send_request_code, 8'hFF, 8'hFF);
    send_packet(3'd7, 8'h00, ~hub_cfg.send_request_code, 8'hFF, 8'hFF);
    send_packet(3'd6, 8'hFF, hub_cfg.send_request_code, 8'h00, 8'h00);
    send_packet(3'd7, 8'hFF, hub_cfg.send_request_code, 8'h01, 8'h00);
    send_packet(3'd2, 8'h7E, hub_cfg.send_request_code, 8'h00, 8'h00);
  endtask

  // fills every free slot with new ids, then one more id must be refused
  task automatic test_table_full();
    logic [ByteW-1:0] fresh [$];
    logic [ByteW-1:0] cand;
    int free_count;
    bit clash;
    drain_answers();
    free_count = 0;
    for (int i = 0; i < SlotCount; i++) if (!slot_taken[i]) free_count++;
    while (fresh.size() < free_count + 1) begin
      cand = ByteW'($urandom);
      clash = 1'b0;
      for (int i = 0; i < SlotCount; i++) if (slot_taken[i] && slot_owner[i] == cand) clash = 1'b1;
      foreach (fresh[j]) if (fresh[j] == cand) clash = 1'b1;
      if (!clash) fresh.push_back(cand);
    end
    foreach (fresh[j]) send_packet(SERVICE_PIPE, fresh[j], ByteW'($urandom), PIPE_REQ_BYTE,
                                   hub_cfg.own_node_id);
    send_packet(3'd5, fresh[0], hub_cfg.send_request_code, 8'h00, 8'h00);
    send_packet(3'd4, fresh[free_count], hub_cfg.send_request_code, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(input int count, input bit with_gaps);
    int roll;
    logic [PipeW-1:0] data_pipe;
    gaps_on = with_gaps;
    repeat (count) begin
      roll = $urandom_range(99);
      data_pipe = PipeW'($urandom_range(1, 7));
      if (roll < 30) begin
        send_packet(SERVICE_PIPE, ($urandom_range(3) == 0) ? ByteW'($urandom) : pick_node_id(),
                    ByteW'($urandom), PIPE_REQ_BYTE, hub_cfg.own_node_id);
      end else if (roll < 65) begin
        send_packet(data_pipe, pick_node_id(), hub_cfg.send_request_code, ByteW'($urandom),
                    ByteW'($urandom));
      end else if (roll < 75) begin
        send_packet(data_pipe, pick_node_id(), ByteW'($urandom), ByteW'($urandom),
                    ByteW'($urandom));
      end else if (roll < 85) begin
        send_packet(data_pipe, ByteW'($urandom), hub_cfg.send_request_code, ByteW'($urandom),
                    ByteW'($urandom));
      end else if (roll < 92) begin
        send_packet(SERVICE_PIPE, pick_node_id(), ByteW'($urandom),
                    ($urandom_range(1) == 0) ? PIPE_REQ_BYTE : ByteW'($urandom),
                    ByteW'($urandom));
      end else begin
        send_packet(PipeW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom),
                    ByteW'($urandom));
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    cfg_t setting;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_service_filter();
    test_registration();
    test_data_pipe();
    setting.own_node_id         = ByteW'($urandom);
    setting.send_request_code   = ByteW'($urandom);
    setting.send_permit_code    = ByteW'($urandom);
    setting.not_registered_code = ByteW'($urandom);
    setting.no_pipe_code        = ByteW'($urandom);
    configure(setting);
    test_random_traffic(120, 1'b1);
    test_table_full();
    configure('{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00});
    test_random_traffic(110, 1'b0);
    configure('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    test_random_traffic(110, 1'b1);
    configure('{8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF});
    test_random_traffic(110, 1'b1);
    drain_answers();
    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("radio_node_registration_handler: match");
    end else begin
      $display("radio_node_registration_handler: mismatch");
    end
    $finish;
  end

endmodule
